// ----- design/length_prefixed_packet_deframer_unit_defines.svh -----
// Assertion macros for the length-prefixed packet deframer.
// Included by the top level; needs no other file.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lpd assertion failed");

`endif

// ----- design/lpd_pkg.sv -----
// Shared types for the length-prefixed packet deframer.
// Used by lpd_front, lpd_fifo and the top level; depends on nothing.
`default_nettype none

package lpd_pkg;

  localparam int unsigned LenW = 15;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_BODY   = 2'd1,
    PHASE_HALT   = 2'd2
  } lpd_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } lpd_in_t;

  typedef struct packed {
    logic                body_valid;
    logic [7:0]          body_byte;
    logic [LenW-1:0]     body_offset;
    logic                packet_done;
    logic signed [15:0]  frame_id;
    logic [LenW-1:0]     body_length;
    logic                error_oversize;
  } lpd_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpd_fifo_stat_t;

endpackage

`default_nettype wire

// ----- design/lpd_front.sv -----
// Front end of the deframer: parses header bytes, tracks the body and
// builds one result per accepted byte. Depends on lpd_pkg.
`default_nettype none

module lpd_front #(
  parameter int unsigned HEADER_BYTES = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire lpd_pkg::lpd_in_t               item_i,
  input  wire logic [lpd_pkg::LenW-1:0]       max_body_i,
  output lpd_pkg::lpd_out_t                   result_o
);

  localparam logic [2:0]  LastCount = 3'(HEADER_BYTES - 1);
  localparam logic [15:0] HdrSize   = 16'(HEADER_BYTES);

  lpd_pkg::lpd_phase_e        phase_q, phase_d;
  logic [2:0]                 hdr_cnt_q, hdr_cnt_d;
  logic [15:0]                size_q, size_d;
  logic [15:0]                id_q, id_d;
  logic [lpd_pkg::LenW-1:0]   rem_q, rem_d;
  logic [lpd_pkg::LenW-1:0]   pos_q, pos_d;

  // Header words including the byte taken this cycle.
  logic [15:0]                size_new, id_new;
  logic                       hdr_last;
  logic [lpd_pkg::LenW-1:0]   body_len;

  always_comb begin
    size_new = size_q;
    id_new   = id_q;
    unique case (hdr_cnt_q)
      3'd0:    size_new = {size_q[15:8], item_i.data_byte};
      3'd1:    size_new = {item_i.data_byte, size_q[7:0]};
      3'd2:    id_new   = {id_q[15:8], item_i.data_byte};
      3'd3:    id_new   = {item_i.data_byte, id_q[7:0]};
      default: ;
    endcase
    hdr_last = (hdr_cnt_q == LastCount);
    // Negative or short total size means an empty body.
    if (!size_new[15] && (size_new > HdrSize)) begin
      body_len = lpd_pkg::LenW'(size_new - HdrSize);
    end else begin
      body_len = '0;
    end
  end

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    size_d    = size_q;
    id_d      = id_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    if (item_i.restart) begin
      phase_d   = lpd_pkg::PHASE_HEADER;
      hdr_cnt_d = '0;
      size_d    = '0;
      id_d      = '0;
      rem_d     = '0;
      pos_d     = '0;
    end else begin
      unique case (phase_q)
        lpd_pkg::PHASE_HEADER: begin
          size_d    = size_new;
          id_d      = id_new;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_last) begin
            hdr_cnt_d = '0;
            if (body_len == '0) begin
              phase_d = lpd_pkg::PHASE_HEADER;
              size_d  = '0;
              id_d    = '0;
              rem_d   = '0;
              pos_d   = '0;
            end else if (body_len > max_body_i) begin
              phase_d = lpd_pkg::PHASE_HALT;
            end else begin
              phase_d = lpd_pkg::PHASE_BODY;
              rem_d   = body_len;
              pos_d   = '0;
            end
          end
        end
        lpd_pkg::PHASE_BODY: begin
          pos_d = pos_q + 1'b1;
          rem_d = rem_q - 1'b1;
          if (rem_q == lpd_pkg::LenW'(1)) begin
            phase_d   = lpd_pkg::PHASE_HEADER;
            hdr_cnt_d = '0;
            size_d    = '0;
            id_d      = '0;
            rem_d     = '0;
            pos_d     = '0;
          end
        end
        default: phase_d = lpd_pkg::PHASE_HALT;
      endcase
    end
  end

  // Result for the byte at the input.
  always_comb begin
    result_o = '0;
    if (!item_i.restart) begin
      unique case (phase_q)
        lpd_pkg::PHASE_HEADER: begin
          if (hdr_last) begin
            if (body_len == '0) begin
              result_o.packet_done = 1'b1;
              result_o.frame_id    = id_new;
            end else if (body_len > max_body_i) begin
              result_o.error_oversize = 1'b1;
            end
          end
        end
        lpd_pkg::PHASE_BODY: begin
          result_o.body_valid  = 1'b1;
          result_o.body_byte   = item_i.data_byte;
          result_o.body_offset = pos_q;
          result_o.frame_id    = id_q;
          result_o.body_length = pos_q + rem_q;
          result_o.packet_done = (rem_q == lpd_pkg::LenW'(1));
        end
        default: result_o.error_oversize = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lpd_pkg::PHASE_HEADER;
      hdr_cnt_q <= '0;
      size_q    <= '0;
      id_q      <= '0;
      rem_q     <= '0;
      pos_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      size_q    <= size_d;
      id_q      <= id_d;
      rem_q     <= rem_d;
      pos_q     <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/lpd_fifo.sv -----
// Short result queue between the parser front end and the output side.
// Depends on lpd_pkg.
`default_nettype none

module lpd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_i,
  input  wire lpd_pkg::lpd_out_t     wr_data_i,
  input  wire logic                  rd_i,
  output lpd_pkg::lpd_out_t          rd_data_o,
  output lpd_pkg::lpd_fifo_stat_t    stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  lpd_pkg::lpd_out_t   mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/length_prefixed_packet_deframer_unit.sv -----
// Top level of the length-prefixed packet deframer: parser front end plus
// result queue. Depends on lpd_pkg, lpd_front, lpd_fifo and the defines header.
//
// Usage:
//   Input channel: drive in_item_i (data_byte, restart) and raise push; a byte
//   transfers at a rising edge with push high and full low.
//   Result channel: while empty is low the oldest result sits on out_item_o;
//   it transfers at a rising edge with pop high.
//   Every input transfer yields exactly one result item.
//   Each result is written into the queue at the edge of its input transfer.
//   Throughput: one byte per clock while full is low; full rises only after
//   FIFO_DEPTH results wait untaken.
//   When the receiver stalls, results pile up in the queue; once it is full
//   the block holds full high and takes no bytes until a pop frees a slot.
//   Reset clears the queue and the parser and sets max_body_q to 1024.
//   Write cfg_we_i/cfg_data_i only while idle; the value applies to the next
//   header that ends.
`default_nettype none
`include "length_prefixed_packet_deframer_unit_defines.svh"

module length_prefixed_packet_deframer_unit #(
  parameter int unsigned HEADER_BYTES = 5,
  parameter int unsigned FIFO_DEPTH   = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire lpd_pkg::lpd_in_t          in_item_i,
  input  wire logic                      pop,
  output logic                           empty,
  output lpd_pkg::lpd_out_t              out_item_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [lpd_pkg::LenW-1:0]  cfg_data_i
);

  logic [lpd_pkg::LenW-1:0] max_body_q;
  logic                     in_xfer;
  lpd_pkg::lpd_out_t        front_res;
  lpd_pkg::lpd_fifo_stat_t  fifo_stat;

  // Hold the limit until a new value is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= lpd_pkg::LenW'(1024);
    end else if (cfg_we_i) begin
      max_body_q <= cfg_data_i;
    end
  end

  assign in_xfer = push && !fifo_stat.full;

  // Advance the parser on every input transfer.
  lpd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .item_i     (in_item_i),
    .max_body_i (max_body_q),
    .result_o   (front_res)
  );

  // Queue results so the two sides stall independently.
  lpd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (in_xfer),
    .wr_data_i (front_res),
    .rd_i      (pop),
    .rd_data_o (out_item_o),
    .stat_o    (fifo_stat)
  );

  assign full  = fifo_stat.full;
  assign empty = fifo_stat.empty;

  // A full queue is never empty.
  `LPD_ASSERT_NOW(a_full_not_empty, clk_i, rst_ni, full, !empty)
  // A transfer into an empty queue with no pop shows a result next cycle.
  `LPD_ASSERT_NEXT(a_push_shows, clk_i, rst_ni, push && !full && empty && !pop, !empty)
  // An oversize error item carries no body byte and no completion.
  `LPD_ASSERT_NOW(a_err_alone, clk_i, rst_ni, !empty && out_item_o.error_oversize,
                  !out_item_o.body_valid && !out_item_o.packet_done)
  // A body byte always lies inside its packet's body.
  `LPD_ASSERT_NOW(a_offset_in_body, clk_i, rst_ni, !empty && out_item_o.body_valid,
                  out_item_o.body_offset < out_item_o.body_length)

endmodule

`default_nettype wire

// ----- tb/sv/tb_length_prefixed_packet_deframer_unit.sv -----
// Self-checking bench for length_prefixed_packet_deframer_unit: random byte streams
// with framed packets, noise and restarts, checked against an in-bench deframer model.
// Depends on lpd_pkg and the RTL of the block.
`timescale 1ns / 100ps

// Scoreboard: mirrors the deframer state and keeps the results still owed by the block.
class packet_scoreboard;
  int unsigned                 hdr_len;
  lpd_pkg::lpd_phase_e         phase;
  logic [2:0]                  hdr_cnt;
  logic [15:0]                 size_word;
  logic [15:0]                 id_word;
  logic [lpd_pkg::LenW-1:0]    remaining;
  logic [lpd_pkg::LenW-1:0]    position;
  logic [lpd_pkg::LenW-1:0]    max_body;
  lpd_pkg::lpd_out_t           expected_results[$];
  int unsigned                 bytes_taken;
  int unsigned                 results_seen;
  int unsigned                 mismatches;

  function new(int unsigned hdr);
    hdr_len = hdr;
    max_body = 15'd1024;
    bytes_taken = 0;
    results_seen = 0;
    mismatches = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    phase = lpd_pkg::PHASE_HEADER;
    hdr_cnt = '0;
    size_word = '0;
    id_word = '0;
    remaining = '0;
    position = '0;
  endfunction

  function void set_max(logic [lpd_pkg::LenW-1:0] v);
    max_body = v;
  endfunction

  // Advance the parser by one byte and return the result it owes.
  function lpd_pkg::lpd_out_t deframe_byte(lpd_pkg::lpd_in_t it);
    lpd_pkg::lpd_out_t        r;
    logic [15:0]              body16;
    logic [lpd_pkg::LenW-1:0] body;
    r = '0;
    if (it.restart) begin
      clear_frame();
      return r;
    end
    if (phase == lpd_pkg::PHASE_BODY) begin
      r.body_valid  = 1'b1;
      r.body_byte   = it.data_byte;
      r.body_offset = position;
      r.frame_id    = id_word;
      r.body_length = position + remaining;
      position  = position + 1'b1;
      remaining = remaining - 1'b1;
      if (remaining == '0) begin
        r.packet_done = 1'b1;
        clear_frame();
      end
      return r;
    end
    if (phase != lpd_pkg::PHASE_HEADER) begin
      phase = lpd_pkg::PHASE_HALT;
      r.error_oversize = 1'b1;
      return r;
    end
    case (hdr_cnt)
      3'd0: size_word[7:0]  = it.data_byte;
      3'd1: size_word[15:8] = it.data_byte;
      3'd2: id_word[7:0]    = it.data_byte;
      3'd3: id_word[15:8]   = it.data_byte;
      default: ;
    endcase
    hdr_cnt = hdr_cnt + 1'b1;
    if (hdr_cnt >= hdr_len) begin
      hdr_cnt = '0;
      body16 = '0;
      if (!size_word[15] && size_word > hdr_len) body16 = size_word - hdr_len;
      body = body16[lpd_pkg::LenW-1:0];
      if (body == '0) begin
        r.packet_done = 1'b1;
        r.frame_id    = id_word;
        clear_frame();
      end else if (body > max_body) begin
        phase = lpd_pkg::PHASE_HALT;
        r.error_oversize = 1'b1;
      end else begin
        phase = lpd_pkg::PHASE_BODY;
        remaining = body;
        position = '0;
      end
    end
    return r;
  endfunction

  function void note_byte(lpd_pkg::lpd_in_t it);
    bytes_taken++;
    expected_results.insert(expected_results.size(), deframe_byte(it));
  endfunction

  task report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d, expected %0d", results_seen, what, got,
             want);
    mismatches++;
  endtask

  task check_result(lpd_pkg::lpd_out_t got);
    lpd_pkg::lpd_out_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, queue depth", 0, 1);
      return;
    end
    want = expected_results[0];
    expected_results.delete(0);
    if (got.body_valid !== want.body_valid)
      report_mismatch("body_valid", got.body_valid, want.body_valid);
    if (got.body_byte !== want.body_byte)
      report_mismatch("body_byte", got.body_byte, want.body_byte);
    if (got.body_offset !== want.body_offset)
      report_mismatch("body_offset", got.body_offset, want.body_offset);
    if (got.packet_done !== want.packet_done)
      report_mismatch("packet_done", got.packet_done, want.packet_done);
    if (got.frame_id !== want.frame_id)
      report_mismatch("frame_id", got.frame_id, want.frame_id);
    if (got.body_length !== want.body_length)
      report_mismatch("body_length", got.body_length, want.body_length);
    if (got.error_oversize !== want.error_oversize)
      report_mismatch("error_oversize", got.error_oversize, want.error_oversize);
  endtask

  task close_out();
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
  endtask
endclass

module tb_length_prefixed_packet_deframer_unit;

  localparam int unsigned HDR = 5;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  lpd_pkg::lpd_in_t         in_item_i = '0;
  logic                     pop = 1'b0;
  logic                     empty;
  lpd_pkg::lpd_out_t        out_item_o;
  logic                     cfg_we_i = 1'b0;
  logic [lpd_pkg::LenW-1:0] cfg_data_i = '0;

  packet_scoreboard sb;

  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  length_prefixed_packet_deframer_unit #(
    .HEADER_BYTES(HDR)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .pop       (pop),
    .empty     (empty),
    .out_item_o(out_item_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Window with no idling on either side.
  function automatic bit calm_window();
    return sb.bytes_taken >= 900 && sb.bytes_taken < 1150;
  endfunction

  // Offer one byte; hold it until the block takes the transfer.
  task automatic send_byte(input logic [7:0] b, input bit rs);
    lpd_pkg::lpd_in_t it;
    it.data_byte = b;
    it.restart   = rs;
    in_item_i <= it;
    forever begin
      push <= calm_window() || ($urandom_range(0, 99) >= 13);
      @(posedge clk_i);
      if (push && !full) begin
        sb.note_byte(it);
        return;
      end
    end
  endtask

  // Byte k of a header; bytes past the id are reserved and random.
  function automatic logic [7:0] header_byte(logic [15:0] total, logic [15:0] id, int k);
    case (k)
      0: return total[7:0];
      1: return total[15:8];
      2: return id[7:0];
      3: return id[15:8];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_header(input logic [15:0] total, input logic [15:0] id);
    for (int k = 0; k < HDR; k++) send_byte(header_byte(total, id, k), 1'b0);
  endtask

  // Drop push and wait until every owed result has been popped.
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [lpd_pkg::LenW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_max(v);
  endtask

  // One random frame: mostly well-formed, the rest oversize, truncated or noise.
  task automatic send_random_frame();
    int          kind;
    int          mx;
    int          cap;
    int          blen;
    int          cut;
    logic [15:0] total;
    logic [15:0] id;
    kind  = $urandom_range(0, 99);
    mx    = int'(sb.max_body);
    cap   = (mx < 300) ? mx : 300;
    id    = 16'($urandom_range(0, 16'hFFFF));
    if (kind < 70) begin
      if ($urandom_range(0, 99) < 6) blen = $urandom_range(0, cap);
      else blen = $urandom_range(0, (cap < 12) ? cap : 12);
      total = 16'(blen + HDR);
      if (blen == 0) begin
        case ($urandom_range(0, 2))
          0: total = 16'(HDR);
          1: total = 16'($urandom_range(0, HDR));
          default: total = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        endcase
      end
      send_header(total, id);
      repeat (blen) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 82) begin
      // Body above the limit: halt, feed up to three dead bytes, then restart.
      if (mx <= 32761) begin
        blen  = mx + 1 + $urandom_range(0, ((32761 - mx) < 200) ? (32761 - mx) : 200);
        total = 16'(blen + HDR);
      end else begin
        total = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      end
      send_header(total, id);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind < 92) begin
      // Cut a frame short anywhere in header or body.
      blen  = $urandom_range(1, 12);
      total = 16'(blen + HDR);
      cut   = $urandom_range(0, HDR + blen - 1);
      for (int k = 0; k < cut; k++) begin
        if (k < HDR) send_byte(header_byte(total, id, k), 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 10);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver: check each popped result, idle at random, stall once for a long stretch.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_item_o);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held_once && sb.bytes_taken >= 500) begin
        held_once = 1'b1;
        hold_left = 299;
        pop <= 1'b0;
      end else begin
        pop <= calm_window() || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  initial begin
    logic [lpd_pkg::LenW-1:0] limits[6];
    int unsigned              target;
    sb = new(HDR);
    limits[0] = 15'd1;
    limits[1] = 15'd0;
    limits[2] = 15'h7FFF;
    limits[3] = 15'($urandom_range(2, 60));
    limits[4] = 15'($urandom_range(1, 32767));
    limits[5] = 15'd1024;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: negative and short totals, body extremes, restart mid-header,
    // oversize at the reset limit followed by a halted byte and a restart.
    send_header(16'hFFFF, 16'h8000);
    send_header(16'(HDR + 2), 16'h7FFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_header(16'd3, 16'h0000);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_header(16'h7FFF, 16'hFFFF);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);

    foreach (limits[p]) begin
      wait_idle();
      write_max(limits[p]);
      target = sb.bytes_taken + 320;
      while (sb.bytes_taken < target) send_random_frame();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/lpd_pkg.sv
design/lpd_front.sv
design/lpd_fifo.sv
design/length_prefixed_packet_deframer_unit.sv
tb/sv/tb_length_prefixed_packet_deframer_unit.sv
